>>> rtl/scba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scba_pkg
// Shared constants, codes and types of the size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   // Size classes and block identifiers
   localparam int CLASS_COUNT  = 4;
   localparam int CLS_W        = 2;
   localparam int BLOCK_ID_W   = 16;
   localparam int MAX_BLOCKS   = 65536;
   localparam int NEXT_W       = 17;   // bump counter and capacity, 0..MAX_BLOCKS
   localparam int CAP_W        = 17;

   // Per-class free stack
   localparam int FREE_DEPTH   = 1024;
   localparam int FREE_ADDR_W  = $clog2(FREE_DEPTH);
   localparam int FREE_CNT_W   = FREE_ADDR_W + 1;
   localparam int STACK_ADDR_W = CLS_W + FREE_ADDR_W;
   localparam int FLUSHED_W    = 13;   // sum of all class fill counts

   // Byte accounting and statistics
   localparam int BYTES_W      = 48;
   localparam int AMOUNT_W     = 41;
   localparam int THRESH_W     = 32;
   localparam int LIVE_W       = 19;
   localparam int TOTAL_W      = 64;
   localparam int FLUSH_CNT_W  = 32;
   localparam logic [LIVE_W-1:0]  LIVE_MAX  = {LIVE_W{1'b1}};
   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLIMITED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USABLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS2    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS3    = 3'd6;

   // Register reset values
   localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd262144;
   localparam logic [AMOUNT_W-1:0] CLASS0_RESET = 41'd65536;
   localparam logic [AMOUNT_W-1:0] CLASS1_RESET = 41'd131072;
   localparam logic [AMOUNT_W-1:0] CLASS2_RESET = 41'd262144;
   localparam logic [AMOUNT_W-1:0] CLASS3_RESET = 41'd524288;

   // Request modes
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;   // power of two
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Classified request as it travels through the queue
   typedef struct packed {
      logic                  is_release;
      logic [CLS_W-1:0]      cls;
      logic [BLOCK_ID_W-1:0] id;
      logic [AMOUNT_W-1:0]   amount;
      logic [FREE_CNT_W-1:0] thresh;
   } op_type;

   // Budget settings used by the back end
   typedef struct packed {
      logic               unlimited;
      logic [BYTES_W-1:0] usable;
   } cfg_type;

   // Back-end sequencer
   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage
`default_nettype wire

>>> rtl/scba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scba_front
// Configuration registers and request classification: looks up the block
// size and derives the flush threshold of the addressed class.
// ----------------------------------------------------------------------------
module scba_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [scba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic                             req_mode,
   input  wire logic [scba_pkg::CLS_W-1:0]       req_size_class,
   input  wire logic [scba_pkg::BLOCK_ID_W-1:0]  req_release_block,
   input  wire logic                             q_full,
   output      logic                             q_push,
   output      scba_pkg::op_type                 q_data,
   output      scba_pkg::cfg_type                cfg
);

   logic                              unlimited_ff;
   logic [scba_pkg::BYTES_W-1:0]      usable_ff;
   logic [scba_pkg::THRESH_W-1:0]     thresh_ff;
   logic [scba_pkg::AMOUNT_W-1:0]     class_bytes_ff [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::THRESH_W-1:0]     shifted;
   logic [scba_pkg::FREE_CNT_W-1:0]   class_thresh;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         unlimited_ff      <= 1'b0;
         usable_ff         <= '0;
         thresh_ff         <= scba_pkg::THRESH_RESET;
         class_bytes_ff[0] <= scba_pkg::CLASS0_RESET;
         class_bytes_ff[1] <= scba_pkg::CLASS1_RESET;
         class_bytes_ff[2] <= scba_pkg::CLASS2_RESET;
         class_bytes_ff[3] <= scba_pkg::CLASS3_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            scba_pkg::CSR_UNLIMITED: unlimited_ff <= csr_wdata[0];
            scba_pkg::CSR_USABLE:    usable_ff <= csr_wdata[scba_pkg::BYTES_W-1:0];
            scba_pkg::CSR_THRESH:    thresh_ff <= csr_wdata[scba_pkg::THRESH_W-1:0];
            scba_pkg::CSR_CLASS0:
               class_bytes_ff[0] <= csr_wdata[scba_pkg::AMOUNT_W-1:0];
            scba_pkg::CSR_CLASS1:
               class_bytes_ff[1] <= csr_wdata[scba_pkg::AMOUNT_W-1:0];
            scba_pkg::CSR_CLASS2:
               class_bytes_ff[2] <= csr_wdata[scba_pkg::AMOUNT_W-1:0];
            scba_pkg::CSR_CLASS3:
               class_bytes_ff[3] <= csr_wdata[scba_pkg::AMOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.unlimited = unlimited_ff;
   assign cfg.usable    = usable_ff;

   // Class threshold: total >> (class+1), at least one, at most the stack depth
   assign shifted = thresh_ff >> ({1'b0, req_size_class} + 3'd1);

   always_comb begin
      if (shifted == '0) begin
         class_thresh = scba_pkg::FREE_CNT_W'(1);
      end else if (shifted > scba_pkg::THRESH_W'(scba_pkg::FREE_DEPTH)) begin
         class_thresh = scba_pkg::FREE_CNT_W'(scba_pkg::FREE_DEPTH);
      end else begin
         class_thresh = shifted[scba_pkg::FREE_CNT_W-1:0];
      end
   end

   // Classified request into the queue
   assign req_ready         = !q_full;
   assign q_push            = req_valid && !q_full;
   assign q_data.is_release = (req_mode == scba_pkg::MODE_RELEASE);
   assign q_data.cls        = req_size_class;
   assign q_data.id         = req_release_block;
   assign q_data.amount     = class_bytes_ff[req_size_class];
   assign q_data.thresh     = class_thresh;

endmodule
`default_nettype wire

>>> rtl/scba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scba_queue
// Short request queue that lets the front and back ends stall on their own.
// ----------------------------------------------------------------------------
module scba_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire scba_pkg::op_type push_data,
   input  wire logic             pop,
   output      logic             full,
   output      logic             empty,
   output      scba_pkg::op_type head
);

   scba_pkg::op_type                 entry_ff [scba_pkg::QUEUE_DEPTH];
   logic [scba_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [scba_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [scba_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (scba_pkg::QUEUE_PTR_W+1)'(scba_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/scba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scba_back
// Carries out allocate and release requests: admission, free stacks, bump
// counters, capacity growth, flushes, statistics and the result register.
// ----------------------------------------------------------------------------
module scba_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire scba_pkg::cfg_type                   cfg,
   input  wire logic                                q_empty,
   input  wire scba_pkg::op_type                    q_head,
   output      logic                                q_pop,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [1:0]                          rsp_status,
   output      logic [scba_pkg::BLOCK_ID_W-1:0]     rsp_granted_block,
   output      logic                                rsp_file_grown,
   output      logic [scba_pkg::CAP_W-1:0]          rsp_class_capacity,
   output      logic [scba_pkg::FLUSHED_W-1:0]      rsp_entries_flushed,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_spilled_now,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_occupied_now,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_spilled_peak,
   output      logic [scba_pkg::LIVE_W-1:0]         rsp_live_blocks,
   output      logic [scba_pkg::TOTAL_W-1:0]        rsp_bytes_reclaimed_total,
   output      logic [scba_pkg::FLUSH_CNT_W-1:0]    rsp_flush_events
);

   localparam int BW = scba_pkg::BYTES_W;

   // Sequencer
   scba_pkg::back_state_type state_ff, state_in;

   // Allocator state
   logic [scba_pkg::FREE_CNT_W-1:0]  free_cnt_ff [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::FREE_CNT_W-1:0]  free_cnt_in [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::NEXT_W-1:0]      next_ff     [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::NEXT_W-1:0]      next_in     [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::CAP_W-1:0]       cap_ff      [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::CAP_W-1:0]       cap_in      [scba_pkg::CLASS_COUNT];
   logic [BW-1:0]                    spill_ff, spill_in;
   logic [BW-1:0]                    occ_ff, occ_in;
   logic [BW-1:0]                    peak_ff, peak_in;
   logic [scba_pkg::LIVE_W-1:0]      live_ff, live_in;
   logic [scba_pkg::TOTAL_W-1:0]     reclaimed_ff, reclaimed_in;
   logic [scba_pkg::FLUSH_CNT_W-1:0] flushes_ff, flushes_in;

   // Free stacks of all classes
   logic [scba_pkg::BLOCK_ID_W-1:0]   stack_mem [1 << scba_pkg::STACK_ADDR_W];
   logic                              mem_we, mem_re;
   logic [scba_pkg::STACK_ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [scba_pkg::BLOCK_ID_W-1:0]   mem_rdata_ff;

   // Evaluation results carried into the commit cycle
   scba_pkg::op_type                 op_ff, op_in;
   logic                             ok_ff, ok_in;
   logic                             flush_all_ff, flush_all_in;
   logic                             has_free_ff, has_free_in;
   logic [scba_pkg::FREE_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BW-1:0]                    diff_ff, diff_in;
   logic [BW-1:0]                    rel_spill_ff, rel_spill_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          status_ff, status_in;
   logic [scba_pkg::BLOCK_ID_W-1:0]     granted_ff, granted_in;
   logic                                grown_ff, grown_in;
   logic [scba_pkg::CAP_W-1:0]          capo_ff, capo_in;
   logic [scba_pkg::FLUSHED_W-1:0]      flushed_ff, flushed_in;

   // Evaluation-side arithmetic on the queue head
   logic [scba_pkg::FREE_CNT_W-1:0] head_cnt, head_cnt_m1;
   logic [BW:0]                     occ_sum, spill_sum_h;
   logic                            fits_occ, fits_spill;

   // Commit-side arithmetic on the latched request
   logic [BW-1:0]                   occ_base;
   logic [BW:0]                     occ_grow_sum, spill_grow_sum;
   logic [BW-1:0]                   occ_grow, spill_grow;
   logic [scba_pkg::FLUSHED_W-1:0]  cnt_sum;
   logic [scba_pkg::FREE_CNT_W-1:0] rel_cnt;
   logic [BW-1:0]                   rel_diff;
   logic [scba_pkg::NEXT_W-1:0]     cur_next;
   logic [scba_pkg::CAP_W-1:0]      cur_cap, cap_dbl;
   logic                            out_free, granted_ok;

   // Admission test against the budget, on the queue head
   assign head_cnt    = free_cnt_ff[q_head.cls];
   assign head_cnt_m1 = head_cnt - 1'b1;
   assign occ_sum     = {1'b0, occ_ff} + (BW+1)'(q_head.amount);
   assign spill_sum_h = {1'b0, spill_ff} + (BW+1)'(q_head.amount);
   assign fits_occ    = cfg.unlimited || (occ_sum <= {1'b0, cfg.usable});
   assign fits_spill  = (spill_sum_h <= {1'b0, cfg.usable});

   // Growth of occupied and spilled bytes, saturating in 48 bits
   assign occ_base       = flush_all_ff ? spill_ff : occ_ff;
   assign occ_grow_sum   = {1'b0, occ_base} + (BW+1)'(op_ff.amount);
   assign occ_grow       = occ_grow_sum[BW] ? scba_pkg::BYTES_MAX : occ_grow_sum[BW-1:0];
   assign spill_grow_sum = {1'b0, spill_ff} + (BW+1)'(op_ff.amount);
   assign spill_grow     = spill_grow_sum[BW] ? scba_pkg::BYTES_MAX
                                              : spill_grow_sum[BW-1:0];

   // Release-side fill count and reclaimed amount
   assign rel_cnt  = (cnt_ff < scba_pkg::FREE_CNT_W'(scba_pkg::FREE_DEPTH))
                     ? cnt_ff + 1'b1 : cnt_ff;
   assign rel_diff = (occ_ff > rel_spill_ff) ? occ_ff - rel_spill_ff : '0;

   // Bump counter and capacity of the latched class
   assign cur_next = next_ff[op_ff.cls];
   assign cur_cap  = cap_ff[op_ff.cls];
   assign cap_dbl  = (cur_cap >= scba_pkg::CAP_W'(scba_pkg::MAX_BLOCKS / 2))
                     ? scba_pkg::CAP_W'(scba_pkg::MAX_BLOCKS) : cur_cap << 1;

   // Entries dropped by a flush of every class
   always_comb begin
      cnt_sum = '0;
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
         cnt_sum = cnt_sum + scba_pkg::FLUSHED_W'(free_cnt_ff[k]);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_raddr = {q_head.cls, head_cnt_m1[scba_pkg::FREE_ADDR_W-1:0]};
   assign mem_waddr = {op_ff.cls, cnt_ff[scba_pkg::FREE_ADDR_W-1:0]};

   // Sequencer: evaluate and read the stack, then commit and answer
   always_comb begin
      state_in     = state_ff;
      free_cnt_in  = free_cnt_ff;
      next_in      = next_ff;
      cap_in       = cap_ff;
      spill_in     = spill_ff;
      occ_in       = occ_ff;
      peak_in      = peak_ff;
      live_in      = live_ff;
      reclaimed_in = reclaimed_ff;
      flushes_in   = flushes_ff;
      op_in        = op_ff;
      ok_in        = ok_ff;
      flush_all_in = flush_all_ff;
      has_free_in  = has_free_ff;
      cnt_in       = cnt_ff;
      diff_in      = diff_ff;
      rel_spill_in = rel_spill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      granted_in   = granted_ff;
      grown_in     = grown_ff;
      capo_in      = capo_ff;
      flushed_in   = flushed_ff;
      q_pop        = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      granted_ok   = 1'b0;

      case (state_ff)
         scba_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               mem_re       = 1'b1;
               op_in        = q_head;
               ok_in        = fits_occ || fits_spill;
               has_free_in  = (head_cnt != '0);
               flush_all_in = !fits_occ && fits_spill && (head_cnt == '0);
               cnt_in       = head_cnt;
               diff_in      = (occ_ff > spill_ff) ? occ_ff - spill_ff : '0;
               rel_spill_in = (spill_ff > BW'(q_head.amount))
                              ? spill_ff - BW'(q_head.amount) : '0;
               state_in     = scba_pkg::BK_EXEC;
            end
         end

         scba_pkg::BK_EXEC: begin
            if (out_free) begin
               status_in  = scba_pkg::STATUS_DONE;
               granted_in = '0;
               grown_in   = 1'b0;
               flushed_in = '0;

               if (!op_ff.is_release) begin
                  // Flush every class list to make room
                  if (flush_all_ff) begin
                     for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
                        free_cnt_in[k] = '0;
                     end
                     flushed_in   = cnt_sum;
                     reclaimed_in = reclaimed_ff + scba_pkg::TOTAL_W'(diff_ff);
                     occ_in       = spill_ff;
                     flushes_in   = flushes_ff + 1'b1;
                  end
                  if (!ok_ff) begin
                     status_in = scba_pkg::STATUS_REFUSED;
                  end else if (has_free_ff) begin
                     // Reuse the most recently freed block of the class
                     free_cnt_in[op_ff.cls] = cnt_ff - 1'b1;
                     granted_in             = mem_rdata_ff;
                     granted_ok             = 1'b1;
                  end else if (cur_next >= scba_pkg::NEXT_W'(scba_pkg::MAX_BLOCKS)) begin
                     status_in = scba_pkg::STATUS_EXHAUSTED;
                  end else begin
                     // Fresh block from the bump counter
                     if (cur_next >= cur_cap) begin
                        cap_in[op_ff.cls] = cap_dbl;
                        grown_in          = 1'b1;
                     end
                     granted_in         = cur_next[scba_pkg::BLOCK_ID_W-1:0];
                     next_in[op_ff.cls] = cur_next + 1'b1;
                     occ_in             = occ_grow;
                     granted_ok         = 1'b1;
                  end
                  if (granted_ok) begin
                     spill_in = spill_grow;
                     if (live_ff != scba_pkg::LIVE_MAX) begin
                        live_in = live_ff + 1'b1;
                     end
                     if (spill_grow > peak_ff) begin
                        peak_in = spill_grow;
                     end
                  end
               end else begin
                  // Push the released block unless the list is full
                  mem_we   = (cnt_ff < scba_pkg::FREE_CNT_W'(scba_pkg::FREE_DEPTH));
                  spill_in = rel_spill_ff;
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
                  // Threshold flush of this class
                  if (rel_cnt >= op_ff.thresh) begin
                     free_cnt_in[op_ff.cls] = '0;
                     flushed_in   = scba_pkg::FLUSHED_W'(rel_cnt);
                     reclaimed_in = reclaimed_ff + scba_pkg::TOTAL_W'(rel_diff);
                     occ_in       = rel_spill_ff;
                     flushes_in   = flushes_ff + 1'b1;
                  end else begin
                     free_cnt_in[op_ff.cls] = rel_cnt;
                  end
               end

               capo_in      = cap_in[op_ff.cls];
               rsp_valid_in = 1'b1;
               state_in     = scba_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = scba_pkg::BK_IDLE;
         end
      endcase
   end

   // Control state and allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scba_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
            free_cnt_ff[k] <= '0;
            next_ff[k]     <= '0;
            cap_ff[k]      <= scba_pkg::CAP_W'(1);
         end
         spill_ff     <= '0;
         occ_ff       <= '0;
         peak_ff      <= '0;
         live_ff      <= '0;
         reclaimed_ff <= '0;
         flushes_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_cnt_ff  <= free_cnt_in;
         next_ff      <= next_in;
         cap_ff       <= cap_in;
         spill_ff     <= spill_in;
         occ_ff       <= occ_in;
         peak_ff      <= peak_in;
         live_ff      <= live_in;
         reclaimed_ff <= reclaimed_in;
         flushes_ff   <= flushes_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ok_ff        <= ok_in;
      flush_all_ff <= flush_all_in;
      has_free_ff  <= has_free_in;
      cnt_ff       <= cnt_in;
      diff_ff      <= diff_in;
      rel_spill_ff <= rel_spill_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      grown_ff     <= grown_in;
      capo_ff      <= capo_in;
      flushed_ff   <= flushed_in;
   end

   // Free stack memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= op_ff.id;
      end
      if (mem_re) begin
         mem_rdata_ff <= stack_mem[mem_raddr];
      end
   end

   // Result channel
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = status_ff;
   assign rsp_granted_block         = granted_ff;
   assign rsp_file_grown            = grown_ff;
   assign rsp_class_capacity        = capo_ff;
   assign rsp_entries_flushed       = flushed_ff;
   assign rsp_spilled_now           = spill_ff;
   assign rsp_occupied_now          = occ_ff;
   assign rsp_spilled_peak          = peak_ff;
   assign rsp_live_blocks           = live_ff;
   assign rsp_bytes_reclaimed_total = reclaimed_ff;
   assign rsp_flush_events          = flushes_ff;

endmodule
`default_nettype wire

>>> rtl/size_class_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Block-ID allocator with four size classes, per-class free stacks, bump
// counters and a byte budget with flushing of freed blocks.
// ----------------------------------------------------------------------------
// A request is classified on transfer (block size and flush threshold of its
// class) and lands in a two-entry queue. The back end takes one request at a
// time: the idle state evaluates admission and reads the shared free-stack
// memory, the exec state commits counters, stack push and statistics into the
// result register once a held result has been taken. The statistics in each
// result are the values after that request. The free-stack memory holds no
// reset state; only entries below a class fill count are ever used.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [scba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [scba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_mode,
   input  wire logic [scba_pkg::CLS_W-1:0]          req_size_class,
   input  wire logic [scba_pkg::BLOCK_ID_W-1:0]     req_release_block,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [1:0]                          rsp_status,
   output      logic [scba_pkg::BLOCK_ID_W-1:0]     rsp_granted_block,
   output      logic                                rsp_file_grown,
   output      logic [scba_pkg::CAP_W-1:0]          rsp_class_capacity,
   output      logic [scba_pkg::FLUSHED_W-1:0]      rsp_entries_flushed,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_spilled_now,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_occupied_now,
   output      logic [scba_pkg::BYTES_W-1:0]        rsp_spilled_peak,
   output      logic [scba_pkg::LIVE_W-1:0]         rsp_live_blocks,
   output      logic [scba_pkg::TOTAL_W-1:0]        rsp_bytes_reclaimed_total,
   output      logic [scba_pkg::FLUSH_CNT_W-1:0]    rsp_flush_events
);

   logic              q_full, q_empty, q_push, q_pop;
   scba_pkg::op_type  q_data, q_head;
   scba_pkg::cfg_type cfg;

   // Configuration and classification
   scba_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_size_class    (req_size_class),
      .req_release_block (req_release_block),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_data),
      .cfg               (cfg)
   );

   // Request queue
   scba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Execution and results
   scba_back u_back (
      .clock                     (clock),
      .reset                     (reset),
      .cfg                       (cfg),
      .q_empty                   (q_empty),
      .q_head                    (q_head),
      .q_pop                     (q_pop),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_status                (rsp_status),
      .rsp_granted_block         (rsp_granted_block),
      .rsp_file_grown            (rsp_file_grown),
      .rsp_class_capacity        (rsp_class_capacity),
      .rsp_entries_flushed       (rsp_entries_flushed),
      .rsp_spilled_now           (rsp_spilled_now),
      .rsp_occupied_now          (rsp_occupied_now),
      .rsp_spilled_peak          (rsp_spilled_peak),
      .rsp_live_blocks           (rsp_live_blocks),
      .rsp_bytes_reclaimed_total (rsp_bytes_reclaimed_total),
      .rsp_flush_events          (rsp_flush_events)
   );

endmodule
`default_nettype wire
